// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the stable priority queue.
// Request and result item structs, stored entry layout, state encoding.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SERVE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_SERVED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   client_id;
        logic [PRIO_W-1:0] priority_req;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   served_id;
        logic [PRIO_W-1:0] served_priority;
        logic [OCC_W-1:0]  occupancy;
    } t_res;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_SRV_RD,
        S_SRV_OUT
    } t_state;

endpackage

// ===== rtl/spq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: sequencer, address unit, entry store.
// Depends on spq_pkg and spq_ram.
`timescale 1ns / 1ps

// Bounded stable priority queue. An item is taken when start is high and busy
// is low. An insert item places its client behind every held entry of equal or
// higher priority, so equal priorities leave first in, first out; a serve item
// removes the head. Every item gives exactly one result, shown for one cycle
// with o_valid high; the receiver cannot stall, so it must take the result in
// that cycle. Entries sit in a circular buffer in one RAM. A serve only moves
// the head pointer, stepping through accept, RAM read and result. An insert
// walks from the tail toward the head, one RAM read and one write per entry
// moved, so its length grows with the entries moved down, as set by the single
// read port and the shared compare. Insert into an empty queue, insert into a
// full one and serve on empty are answered straight from the idle state. The
// occupancy field is 5 bits wide, which covers DEPTH up to 31. No clearing pass
// follows reset: only entries inside the count are ever read.
module stable_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::t_req i_req,
    output logic          o_valid,
    output spq_pkg::t_res o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    spq_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_k, n_k;          // logical slot being filled
    spq_pkg::t_req   r_req, n_req;
    spq_pkg::t_res   r_res, n_res;
    logic            r_valid, n_valid;

    // shared address unit: physical = (head + offset) mod DEPTH
    logic [CW-1:0] a_off;
    logic [AW:0]   a_sum;
    logic [AW-1:0] a_phys;

    // RAM port signals
    logic            ram_we;
    spq_pkg::t_entry ram_wdata;
    spq_pkg::t_entry ram_rdata;
    spq_pkg::t_entry new_entry;

    assign a_sum  = (AW + 1)'(r_head) + (AW + 1)'(a_off);
    assign a_phys = (a_sum >= (AW + 1)'(DEPTH)) ? AW'(a_sum - (AW + 1)'(DEPTH))
                                                 : a_sum[AW-1:0];

    assign new_entry.prio = r_req.priority_req;
    assign new_entry.id   = r_req.client_id;

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (a_phys),
        .i_wdata (ram_wdata),
        .i_raddr (a_phys),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_k     <= n_k;
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_k       = r_k;
        n_req     = r_req;
        n_res     = r_res;
        n_valid   = 1'b0;
        a_off     = '0;
        ram_we    = 1'b0;
        ram_wdata = new_entry;

        unique case (r_state)
            spq_pkg::S_IDLE: begin
                if (start) begin
                    n_req                 = i_req;
                    n_res.served_id       = '0;
                    n_res.served_priority = '0;
                    n_res.occupancy       = spq_pkg::OCC_W'(r_count);
                    if (i_req.req_type == spq_pkg::REQ_INSERT) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res.status = spq_pkg::ST_FULL;
                            n_valid      = 1'b1;
                        end else if (r_count == '0) begin
                            // empty: write straight at the head
                            ram_we          = 1'b1;
                            ram_wdata.prio  = i_req.priority_req;
                            ram_wdata.id    = i_req.client_id;
                            n_count         = r_count + 1'b1;
                            n_res.status    = spq_pkg::ST_INSERTED;
                            n_res.occupancy = spq_pkg::OCC_W'(n_count);
                            n_valid         = 1'b1;
                        end else begin
                            n_k     = r_count;
                            n_state = spq_pkg::S_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status = spq_pkg::ST_EMPTY;
                            n_valid      = 1'b1;
                        end else begin
                            n_state = spq_pkg::S_SRV_RD;
                        end
                    end
                end
            end

            spq_pkg::S_INS_RD: begin
                a_off   = r_k - 1'b1;
                n_state = spq_pkg::S_INS_CMP;
            end

            spq_pkg::S_INS_CMP: begin
                a_off  = r_k;
                ram_we = 1'b1;
                if (ram_rdata.prio < r_req.priority_req) begin
                    // new item goes ahead: move this entry one slot back
                    ram_wdata = ram_rdata;
                    n_k       = r_k - 1'b1;
                    n_state   = (r_k == CW'(1)) ? spq_pkg::S_INS_PUT
                                                : spq_pkg::S_INS_RD;
                end else begin
                    n_count         = r_count + 1'b1;
                    n_res.status    = spq_pkg::ST_INSERTED;
                    n_res.occupancy = spq_pkg::OCC_W'(n_count);
                    n_valid         = 1'b1;
                    n_state         = spq_pkg::S_IDLE;
                end
            end

            spq_pkg::S_INS_PUT: begin
                a_off           = r_k;
                ram_we          = 1'b1;
                n_count         = r_count + 1'b1;
                n_res.status    = spq_pkg::ST_INSERTED;
                n_res.occupancy = spq_pkg::OCC_W'(n_count);
                n_valid         = 1'b1;
                n_state         = spq_pkg::S_IDLE;
            end

            spq_pkg::S_SRV_RD: begin
                a_off   = '0;
                n_state = spq_pkg::S_SRV_OUT;
            end

            spq_pkg::S_SRV_OUT: begin
                a_off                 = CW'(1);
                n_head                = a_phys;
                n_count               = r_count - 1'b1;
                n_res.status          = spq_pkg::ST_SERVED;
                n_res.served_id       = ram_rdata.id;
                n_res.served_priority = ram_rdata.prio;
                n_res.occupancy       = spq_pkg::OCC_W'(n_count);
                n_valid               = 1'b1;
                n_state               = spq_pkg::S_IDLE;
            end

            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != spq_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTH
    // count never passes the store size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above DEPTH");

    // a RAM read cycle never produces a result the next cycle
    a_rd_no_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spq_pkg::S_INS_RD || r_state == spq_pkg::S_SRV_RD) |=> !o_valid)
        else $error("result during RAM read");

    // reported occupancy matches the held count
    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.occupancy == spq_pkg::OCC_W'(r_count)))
        else $error("occupancy mismatch");

    // a served result removes exactly one entry
    a_serve_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == spq_pkg::ST_SERVED && $past(i_rst_n))
            |-> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("serve did not drop count by one");
`endif

endmodule
